// ===== design/bscd_pkg.sv =====
package bscd_pkg;

	// String classes, narrow to wide.
	localparam logic [2:0] CLS_EMPTY     = 3'd0;
	localparam logic [2:0] CLS_NUMERIC   = 3'd1;
	localparam logic [2:0] CLS_ALPHA     = 3'd2;
	localparam logic [2:0] CLS_ALNUM     = 3'd3;
	localparam logic [2:0] CLS_BASE64    = 3'd4;
	localparam logic [2:0] CLS_PRINTABLE = 3'd5;
	localparam logic [2:0] CLS_READABLE  = 3'd6;
	localparam logic [2:0] CLS_BINARY    = 3'd7;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_PAD   = 8'h3D;

	localparam logic [1:0] PAD_RUN_MAX = 2'd3;
	localparam logic [1:0] PAD_RUN_OK  = 2'd2;

	// One input word as held in the input register.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_byte;
		logic       last_byte;
	} item_t;

	// Running state of the string being classified.
	typedef struct packed {
		logic [2:0] cls;
		logic [1:0] len_mod;
		logic       at_least_four;
		logic [1:0] pad_run;
		logic       pad_misplaced;
	} track_t;

	localparam track_t TRACK_RESET = '{
		cls: CLS_EMPTY, len_mod: 2'd0, at_least_four: 1'b0,
		pad_run: 2'd0, pad_misplaced: 1'b0
	};

	// Narrowest class that holds a single byte, C-locale rules.
	function automatic logic [2:0] byte_class(input logic [7:0] c);
		logic [2:0] t;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = CLS_NUMERIC;
		end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
			t = CLS_ALPHA;
		end else if (c == CHAR_PLUS || c == CHAR_SLASH || c == CHAR_PAD) begin
			t = CLS_BASE64;
		end else if (c >= 8'h20 && c <= 8'h7E) begin
			t = CLS_PRINTABLE;
		end else if (c >= 8'h09 && c <= 8'h0D) begin
			t = CLS_READABLE;
		end else begin
			t = CLS_BINARY;
		end
		return t;
	endfunction

endpackage

// ===== design/bscd_in_reg.sv =====
module bscd_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [7:0]      s_axis_tdata,   // [7:0] char_byte
	input  logic            s_axis_tuser,   // [0] has_byte
	input  logic            s_axis_tlast,   // last_byte
	input  logic            advance,
	output logic            item_valid,
	output bscd_pkg::item_t item
);
	import bscd_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// The register takes a new word whenever it is empty or its word moves on.
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= '{char_byte: s_axis_tdata, has_byte: s_axis_tuser,
				last_byte: s_axis_tlast};
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ===== design/bscd_tracker.sv =====
module bscd_tracker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  bscd_pkg::item_t item,
	output logic [2:0]      result_class
);
	import bscd_pkg::*;

	track_t     track_q;
	track_t     track_next;
	logic [2:0] t;
	logic       b64_ok;

	assign t = byte_class(item.char_byte);

	// Fold the byte into the running state.
	always_comb begin
		track_next = track_q;
		if (item.has_byte) begin
			if (track_q.cls < CLS_BASE64) begin
				track_next.cls = (t >= CLS_BASE64) ? t : (track_q.cls | t);
			end else if (t > track_q.cls) begin
				track_next.cls = t;
			end
			track_next.len_mod = track_q.len_mod + 2'd1;
			if (track_q.len_mod == 2'd3) begin
				track_next.at_least_four = 1'b1;
			end
			if (item.char_byte == CHAR_PAD) begin
				if (track_q.pad_run != PAD_RUN_MAX) begin
					track_next.pad_run = track_q.pad_run + 2'd1;
				end
			end else begin
				if (track_q.pad_run != 2'd0) begin
					track_next.pad_misplaced = 1'b1;
				end
				track_next.pad_run = 2'd0;
			end
		end
	end

	// Base64 shape check; a failing base64 string reads as printable.
	assign b64_ok = track_next.at_least_four && (track_next.len_mod == 2'd0) &&
		!track_next.pad_misplaced && (track_next.pad_run <= PAD_RUN_OK);

	assign result_class = (track_next.cls == CLS_BASE64 && !b64_ok) ?
		CLS_PRINTABLE : track_next.cls;

	// The state returns to reset once a string closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= TRACK_RESET;
		end else if (take) begin
			track_q <= item.last_byte ? TRACK_RESET : track_next;
		end
	end

endmodule

// ===== design/byte_string_class_detector.sv =====
// A word that closes a string passes through one input register, then the result
// register, which holds its result word.
// Throughput: one word per clock; only a word that closes a string waits in the
// input register, and only while the previous result word is still unread.
// Reset: arst_n clears the valid flags and the running string state at once.
module byte_string_class_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
	input  logic       s_axis_tuser,   // [0] has_byte
	input  logic       s_axis_tlast,   // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [2:0] string_class, [7:3] zero
);
	import bscd_pkg::*;

	item_t      item;
	logic       item_valid;
	logic       advance;
	logic       take;
	logic [2:0] result_class;
	logic       out_valid_q;
	logic [2:0] out_class_q;

	// A word moves on unless it closes a string and the result register is full and not being read.
	assign advance = !item.last_byte || !out_valid_q || m_axis_tready;
	assign take    = item_valid && advance;

	bscd_in_reg u_in_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.advance      (advance),
		.item_valid   (item_valid),
		.item         (item)
	);

	bscd_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.item        (item),
		.result_class(result_class)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && item.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.last_byte) begin
			out_class_q <= result_class;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_class_q};

endmodule

// ===== verif/byte_string_class_detector_tb.sv =====
`timescale 1ns / 100ps

module byte_string_class_detector_tb;
	import bscd_pkg::*;

	typedef logic [7:0] text_t[$];

	// Content flavors used to build random strings.
	typedef enum int {
		FL_DIGIT,
		FL_ALPHA,
		FL_ALNUM,
		FL_B64,
		FL_PRINT,
		FL_READ,
		FL_BINARY
	} flavor_t;

	// Tracks the running class of the open string and holds the classes still owed.
	class class_scoreboard;
		logic [2:0] run_class;
		logic [1:0] len_mod;
		logic       four_seen;
		logic [1:0] pad_run;
		logic       pad_misplaced;
		logic [2:0] expected_classes[$];
		int unsigned failures;

		function new();
			clear_run();
			failures = 0;
		endfunction

		function void clear_run();
			run_class = CLS_EMPTY;
			len_mod = 2'd0;
			four_seen = 1'b0;
			pad_run = 2'd0;
			pad_misplaced = 1'b0;
		endfunction

		// Folds one accepted word into the running state.
		function void note_word(logic [7:0] c, logic has, logic last);
			logic [2:0] kind;
			logic [2:0] final_class;
			logic       shape_ok;
			if (has) begin
				if (c >= 8'h30 && c <= 8'h39) begin
					kind = CLS_NUMERIC;
				end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
					kind = CLS_ALPHA;
				end else if (c == CHAR_PLUS || c == CHAR_SLASH || c == CHAR_PAD) begin
					kind = CLS_BASE64;
				end else if (c >= 8'h20 && c <= 8'h7E) begin
					kind = CLS_PRINTABLE;
				end else if (c >= 8'h09 && c <= 8'h0D) begin
					kind = CLS_READABLE;
				end else begin
					kind = CLS_BINARY;
				end
				// Below base64, digits and letters merge into alphanumeric.
				if (run_class < CLS_BASE64) begin
					run_class = (kind >= CLS_BASE64) ? kind : (run_class | kind);
				end else begin
					if (kind < CLS_BASE64)
						kind = CLS_BASE64;
					if (kind > run_class)
						run_class = kind;
				end
				len_mod = len_mod + 2'd1;
				if (len_mod == 2'd0)
					four_seen = 1'b1;
				if (c == CHAR_PAD) begin
					if (pad_run != PAD_RUN_MAX)
						pad_run = pad_run + 2'd1;
				end else begin
					if (pad_run != 2'd0)
						pad_misplaced = 1'b1;
					pad_run = 2'd0;
				end
			end
			if (last) begin
				final_class = run_class;
				// A base64 string must also have the right shape.
				shape_ok = four_seen && len_mod == 2'd0 && !pad_misplaced &&
					pad_run <= PAD_RUN_OK;
				if (final_class == CLS_BASE64 && !shape_ok)
					final_class = CLS_PRINTABLE;
				expected_classes.insert(expected_classes.size(), final_class);
				clear_run();
			end
		endfunction

		function void check_result(logic [7:0] word);
			logic [2:0] want;
			if (expected_classes.size() == 0) begin
				$error("string_class: no result expected, actual %0d", word[2:0]);
				failures++;
				return;
			end
			want = expected_classes.pop_front();
			if (word[2:0] !== want) begin
				$error("string_class: expected %0d, actual %0d", want, word[2:0]);
				failures++;
			end
			if (word[7:3] !== 5'd0) begin
				$error("tdata[7:3]: expected 0, actual %0d", word[7:3]);
				failures++;
			end
		endfunction

		function int pending();
			return expected_classes.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;   // [7:0] char_byte
	logic       s_axis_tuser = 1'b0;   // [0] has_byte
	logic       s_axis_tlast = 1'b0;   // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [2:0] string_class, [7:3] zero

	class_scoreboard sb = new();
	bit          idle_on = 1'b1;
	int unsigned items_sent = 0;

	byte_string_class_detector i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offers one word, with random gaps ahead of it, and waits for the handshake.
	task automatic send_word(input logic [7:0] c, input logic has, input logic last);
		while (idle_on && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tuser <= has;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_word(c, has, last);
		if (has || last)
			items_sent++;
	endtask

	// Sends a non-empty string, with stray byte-less words in between.
	// The string closes either on its last byte or with a separate byte-less word.
	task automatic send_string(input text_t text, input bit close_apart);
		for (int i = 0; i < text.size(); i++) begin
			if ($urandom_range(11) == 0)
				send_word(8'($urandom_range(255)), 1'b0, 1'b0);
			send_word(text[i], 1'b1, (i == text.size() - 1) && !close_apart);
		end
		if (close_apart)
			send_word(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	function automatic logic [7:0] random_byte(flavor_t fl);
		int unsigned r;
		case (fl)
			FL_DIGIT: begin
				return 8'h30 + 8'($urandom_range(9));
			end
			FL_ALPHA: begin
				return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
			end
			FL_ALNUM: begin
				return random_byte($urandom_range(1) ? FL_DIGIT : FL_ALPHA);
			end
			FL_B64: begin
				r = $urandom_range(63);
				if (r < 10)
					return 8'h30 + 8'(r);
				else if (r < 36)
					return 8'h41 + 8'(r - 10);
				else if (r < 62)
					return 8'h61 + 8'(r - 36);
				else
					return (r == 62) ? CHAR_PLUS : CHAR_SLASH;
			end
			FL_PRINT: begin
				return 8'h20 + 8'($urandom_range(94));
			end
			FL_READ: begin
				if ($urandom_range(2) == 0)
					return 8'h09 + 8'($urandom_range(4));
				return 8'h20 + 8'($urandom_range(94));
			end
			default: begin
				return 8'($urandom_range(255));
			end
		endcase
	endfunction

	// Collects result words and stalls the result side at random.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			m_axis_tready <= !(idle_on && $urandom_range(99) < 22);
		end
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		text_t   text;
		flavor_t fl;
		int      len;
		int      pads;
		bit      paused_once;

		paused_once = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: every class, the byte extremes and the closing forms.
		send_word(8'hFF, 1'b0, 1'b1);
		send_string('{8'h30}, 1'b0);
		send_string('{8'h39, 8'h5A}, 1'b0);
		send_string('{8'h7A}, 1'b0);
		send_string('{CHAR_PLUS, CHAR_SLASH, 8'h41, CHAR_PAD}, 1'b0);
		send_string('{8'h7E}, 1'b0);
		send_string('{8'h20}, 1'b0);
		send_string('{8'h09, 8'h0D}, 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hA5, 1'b0, 1'b0);
		send_word(8'h7F, 1'b1, 1'b1);
		send_string('{CHAR_PAD, CHAR_PAD, CHAR_PAD, CHAR_PAD}, 1'b0);
		send_string('{CHAR_PAD}, 1'b1);
		send_string('{8'h80}, 1'b0);

		// Random strings, mostly of one flavor with the odd foreign byte.
		while (items_sent < 1350) begin
			idle_on = !(items_sent >= 400 && items_sent < 750);
			if ($urandom_range(29) == 0) begin
				send_word(8'($urandom_range(255)), 1'b0, 1'b1);
				continue;
			end
			fl = flavor_t'($urandom_range(6));
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
			text.delete();
			if (fl == FL_B64) begin
				// Base64 with zero to two pad bytes, broken in half the cases (extra byte, stray pad, three pads, short).
				len = 4 * $urandom_range(4, 1);
				for (int i = 0; i < len; i++)
					text.insert(text.size(), random_byte(FL_B64));
				pads = $urandom_range(2);
				for (int i = 0; i < pads; i++)
					text[len - 1 - i] = CHAR_PAD;
				case ($urandom_range(7))
					0: text.insert(text.size(), random_byte(FL_B64));
					1: text[$urandom_range(len - 3)] = CHAR_PAD;
					2: begin
						for (int i = 0; i < 3; i++)
							text[len - 1 - i] = CHAR_PAD;
					end
					3: void'(text.pop_back());
					default: ;
				endcase
			end else begin
				for (int i = 0; i < len; i++)
					text.insert(text.size(), ($urandom_range(9) == 0) ?
						random_byte(flavor_t'($urandom_range(6))) : random_byte(fl));
			end
			send_string(text, $urandom_range(3) == 0);

			// Now and then let every owed result drain before going on.
			if ((!paused_once && items_sent > 300) || $urandom_range(24) == 0) begin
				paused_once = 1'b1;
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0)
					@(posedge clk);
			end
		end

		idle_on = 1'b1;
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/bscd_pkg.sv
design/bscd_in_reg.sv
design/bscd_tracker.sv
design/byte_string_class_detector.sv
verif/byte_string_class_detector_tb.sv
